FILE: hw/rtl/sdb_pkg.sv
package sdb_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIME_BITS   = 32;
    localparam int IVL_BITS    = 16;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    typedef enum logic [1:0] {
        MODE_STABLE  = 2'd0,
        MODE_LOCKOUT = 2'd1,
        MODE_PROMPT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_INTERVAL  = 2'd1,
        REG_ANALOG    = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

    localparam logic [1:0]             MODE_RESET      = 2'd0;
    localparam logic [IVL_BITS-1:0]    INTERVAL_RESET  = 16'd10;
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = 10'd512;

    typedef struct packed {
        logic [1:0]             debounce_mode;
        logic [IVL_BITS-1:0]    interval_ms;
        logic                   analog_input;
        logic [SAMPLE_BITS-1:0] noise_threshold;
    } cfg_t;

    typedef struct packed {
        logic                   changed;
        logic                   level;
        logic                   rose;
        logic                   fell;
        logic [SAMPLE_BITS-1:0] raw_sample;
    } res_t;

endpackage

FILE: hw/rtl/sdb_if.sv
interface sdb_poll_if
    import sdb_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [TIME_BITS-1:0]   now_ms;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output now_ms, output sample_value, input ready);
    modport sink   (input valid, input now_ms, input sample_value, output ready);
endinterface

interface sdb_result_if
    import sdb_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   changed;
    logic                   level;
    logic                   rose;
    logic                   fell;
    logic [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output changed, output level, output rose, output fell,
                    output raw_sample, input ready);
    modport sink   (input valid, input changed, input level, input rose, input fell,
                    input raw_sample, output ready);
endinterface

FILE: hw/rtl/sdb_regs.sv
module sdb_regs
    import sdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_mode   <= MODE_RESET;
            cfg_reg.interval_ms     <= INTERVAL_RESET;
            cfg_reg.analog_input    <= 1'b0;
            cfg_reg.noise_threshold <= THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MODE:      cfg_reg.debounce_mode   <= pwdata[1:0];
                REG_INTERVAL:  cfg_reg.interval_ms     <= pwdata[IVL_BITS-1:0];
                REG_ANALOG:    cfg_reg.analog_input    <= pwdata[0];
                REG_THRESHOLD: cfg_reg.noise_threshold <= pwdata[SAMPLE_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:      prdata = {{(DATA_BITS-2){1'b0}}, cfg_reg.debounce_mode};
            REG_INTERVAL:  prdata = {{(DATA_BITS-IVL_BITS){1'b0}}, cfg_reg.interval_ms};
            REG_ANALOG:    prdata = {{(DATA_BITS-1){1'b0}}, cfg_reg.analog_input};
            REG_THRESHOLD: prdata = {{(DATA_BITS-SAMPLE_BITS){1'b0}}, cfg_reg.noise_threshold};
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/sdb_step.sv
module sdb_step
    import sdb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [TIME_BITS-1:0]   now_ms,
    input  logic [SAMPLE_BITS-1:0] sample_value,
    input  cfg_t                   cfg,
    output res_t                   res
);

    logic                   level_reg, level_next;
    logic                   raw_reg, raw_next;
    logic [TIME_BITS-1:0]   stamp_reg, stamp_next;
    logic [SAMPLE_BITS-1:0] held_reg, held_next;
    logic                   chg;
    logic                   cur;
    logic [TIME_BITS-1:0]   stamp_mid;
    logic [TIME_BITS-1:0]   ivl_ext;
    logic                   over_old;
    logic                   over_mid;

    assign ivl_ext = {{(TIME_BITS-IVL_BITS){1'b0}}, cfg.interval_ms};
    assign cur     = cfg.analog_input ? (sample_value > cfg.noise_threshold) : sample_value[0];
    // stable mode measures from a raw edge seen on this very poll
    assign stamp_mid = (cur != raw_reg) ? now_ms : stamp_reg;
    assign over_old  = (now_ms - stamp_reg) >= ivl_ext;
    assign over_mid  = (now_ms - stamp_mid) >= ivl_ext;

    always_comb
    begin
        level_next = level_reg;
        raw_next   = raw_reg;
        stamp_next = stamp_reg;
        held_next  = held_reg;
        chg        = 1'b0;
        case (cfg.debounce_mode)
            MODE_LOCKOUT:
            begin
                // inside the window: take nothing
                if (over_old)
                begin
                    held_next = sample_value;
                    if (cur != level_reg)
                    begin
                        stamp_next = now_ms;
                        level_next = cur;
                        chg        = 1'b1;
                    end
                end
            end
            MODE_PROMPT:
            begin
                held_next = sample_value;
                if (cur != level_reg && over_old)
                begin
                    level_next = cur;
                    chg        = 1'b1;
                end
                if (cur != raw_reg)
                begin
                    raw_next   = cur;
                    stamp_next = now_ms;
                end
            end
            default:
            begin
                held_next  = sample_value;
                raw_next   = cur;
                stamp_next = stamp_mid;
                if (over_mid && cur != level_reg)
                begin
                    stamp_next = now_ms;
                    level_next = cur;
                    chg        = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            raw_reg   <= 1'b0;
            stamp_reg <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            level_reg <= level_next;
            raw_reg   <= raw_next;
            stamp_reg <= stamp_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        res.changed    = chg;
        res.level      = level_next;
        res.rose       = chg && level_next;
        res.fell       = chg && !level_next;
        res.raw_sample = held_next;
    end

endmodule

FILE: hw/rtl/switch_debouncer_three_mode.sv
// Switch debouncer with stable-interval, lock-out and prompt modes.
// poll carries one switch poll per transfer: a free-running millisecond
// time stamp and a raw sample (digital level in bit 0, or an ADC value
// compared with the noise threshold). result returns exactly one transfer
// per poll: changed, debounced level, rose, fell and the held sample.
// The result is registered and shows in the cycle after the poll is taken.
// Throughput is one poll per cycle while results are taken; the debounce
// state is updated in the same cycle the poll is taken and the result goes
// to a single output register. When the receiver stalls, the output
// register holds and poll ready drops until the result is taken; a poll
// is taken in the cycle the waiting result leaves.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12:
// mode, interval in ms, analog select, noise threshold. Write it only while
// no poll is in flight.
// Reset clears the debounced level, the last raw level, the change time and
// the held sample, and loads mode 0, interval 10 ms, digital input and
// threshold 512.
module switch_debouncer_three_mode
    import sdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    sdb_poll_if.sink             poll,
    sdb_result_if.source         result
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic valid_reg;
    logic accept;

    sdb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign poll.ready = !valid_reg || result.ready;
    assign accept     = poll.valid && poll.ready;

    sdb_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .now_ms       (poll.now_ms),
        .sample_value (poll.sample_value),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign result.valid      = valid_reg;
    assign result.changed    = res_reg.changed;
    assign result.level      = res_reg.level;
    assign result.rose       = res_reg.rose;
    assign result.fell       = res_reg.fell;
    assign result.raw_sample = res_reg.raw_sample;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted poll left no result");

    a_stall_blocks_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !poll.ready)
        else $error("poll taken while result waits");

    a_edge_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.rose || result.fell) == result.changed)
                         && !(result.rose && result.fell))
        else $error("rose/fell disagree with changed");

endmodule

FILE: tb/tb_switch_debouncer_three_mode.sv
`timescale 1ns / 100ps

module tb_switch_debouncer_three_mode;
    import sdb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_AT    = 300;
    localparam int STALL_LEN   = 80;
    localparam int IDLE_PCT    = 21;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [TIME_BITS-1:0]   now_ms;
        logic [SAMPLE_BITS-1:0] sample_value;
    } poll_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    sdb_poll_if   poll_bus ();
    sdb_result_if result_bus ();

    switch_debouncer_three_mode i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .poll    (poll_bus),
        .result  (result_bus)
    );

    always #2 clk = ~clk;

    // Shadow of the block: register settings and debounce state
    cfg_t                   sw_cfg;
    logic                   sw_level;
    logic                   sw_raw_level;
    logic [TIME_BITS-1:0]   sw_change_time;
    logic [SAMPLE_BITS-1:0] sw_held;

    poll_item_t pending_polls[$];
    res_t       due_reports[$];

    logic                 poll_fired = 1'b0;
    logic                 send_steady = 1'b0;
    logic                 recv_steady = 1'b0;
    int                   polls_taken = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   stall_left = 0;
    bit                   stalled_once = 1'b0;
    logic [TIME_BITS-1:0] t_ms = '0;

    task automatic debounce_step(input logic [TIME_BITS-1:0] now,
                                 input logic [SAMPLE_BITS-1:0] sample,
                                 output res_t report);
        logic                 cur;
        logic                 flag;
        logic [TIME_BITS-1:0] since;
        cur   = sw_cfg.analog_input ? (sample > sw_cfg.noise_threshold) : sample[0];
        flag  = 1'b0;
        since = now - sw_change_time;
        case (sw_cfg.debounce_mode)
            MODE_LOCKOUT:
            begin
                // inside the window no sample is taken at all
                if (since >= TIME_BITS'(sw_cfg.interval_ms))
                begin
                    sw_held = sample;
                    if (cur != sw_level)
                    begin
                        sw_change_time = now;
                        sw_level       = cur;
                        flag           = 1'b1;
                    end
                end
            end
            MODE_PROMPT:
            begin
                sw_held = sample;
                if (cur != sw_level && since >= TIME_BITS'(sw_cfg.interval_ms))
                begin
                    sw_level = cur;
                    flag     = 1'b1;
                end
                if (cur != sw_raw_level)
                begin
                    sw_raw_level   = cur;
                    sw_change_time = now;
                end
            end
            default:
            begin
                sw_held = sample;
                if (cur != sw_raw_level)
                begin
                    sw_raw_level   = cur;
                    sw_change_time = now;
                end
                since = now - sw_change_time;
                if (since >= TIME_BITS'(sw_cfg.interval_ms) && cur != sw_level)
                begin
                    sw_change_time = now;
                    sw_level       = cur;
                    flag           = 1'b1;
                end
            end
        endcase
        report.changed    = flag;
        report.level      = sw_level;
        report.rose       = flag & sw_level;
        report.fell       = flag & ~sw_level;
        report.raw_sample = sw_held;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Poll driver: hold an offer until it is taken, then load the next one
    always @(negedge clk)
    begin : drive_polls
        poll_item_t item;
        if (rst_n && (!poll_bus.valid || poll_fired))
        begin
            if (pending_polls.size() != 0 && (send_steady || $urandom_range(99) >= IDLE_PCT))
            begin
                item = pending_polls.pop_front();
                poll_bus.valid        <= 1'b1;
                poll_bus.now_ms       <= item.now_ms;
                poll_bus.sample_value <= item.sample_value;
            end
            else
                poll_bus.valid <= 1'b0;
        end
    end

    // Result receiver, with one long hold-off once the traffic is under way
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (!stalled_once && polls_taken >= STALL_AT)
            begin
                stalled_once = 1'b1;
                stall_left   = STALL_LEN;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= recv_steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : watch_transfers
        res_t report;
        res_t due;
        if (rst_n)
        begin
            poll_fired <= poll_bus.valid && poll_bus.ready;
            if (poll_bus.valid && poll_bus.ready)
            begin
                debounce_step(poll_bus.now_ms, poll_bus.sample_value, report);
                due_reports.push_back(report);
                polls_taken++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("result transfer with no poll outstanding");
                    fail_count++;
                end
                else
                begin
                    due = due_reports.pop_front();
                    check_field("changed", due.changed, result_bus.changed);
                    check_field("level", due.level, result_bus.level);
                    check_field("rose", due.rose, result_bus.rose);
                    check_field("fell", due.fell, result_bus.fell);
                    check_field("raw_sample", due.raw_sample, result_bus.raw_sample);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("switch_debouncer_three_mode test failed");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:      sw_cfg.debounce_mode   = value[1:0];
            REG_INTERVAL:  sw_cfg.interval_ms     = value[IVL_BITS-1:0];
            REG_ANALOG:    sw_cfg.analog_input    = value[0];
            REG_THRESHOLD: sw_cfg.noise_threshold = value[SAMPLE_BITS-1:0];
            default:       ;
        endcase
    endtask

    task automatic set_mode(input logic [1:0] mode, input int interval, input bit analog,
                            input int threshold);
        write_reg(REG_MODE, DATA_BITS'(mode));
        write_reg(REG_INTERVAL, DATA_BITS'(interval));
        write_reg(REG_ANALOG, DATA_BITS'(analog));
        write_reg(REG_THRESHOLD, DATA_BITS'(threshold));
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_polls.size() != 0 || poll_bus.valid || due_reports.size() != 0);
    endtask

    task automatic offer_poll(input logic [TIME_BITS-1:0] now, input int sample);
        poll_item_t item;
        item.now_ms       = now;
        item.sample_value = SAMPLE_BITS'(sample);
        pending_polls.push_back(item);
        t_ms = now;
    endtask

    function automatic int pick_sample(input logic lvl);
        logic [SAMPLE_BITS-1:0] s;
        int                     thr;
        thr = int'(sw_cfg.noise_threshold);
        s   = SAMPLE_BITS'($urandom);
        if (!sw_cfg.analog_input)
            s[0] = lvl;
        else if (lvl && thr != SAMPLE_MAX)
            s = SAMPLE_BITS'(($urandom_range(3) == 0) ? thr + 1
                                                      : $urandom_range(SAMPLE_MAX, thr + 1));
        else if (!lvl)
            s = SAMPLE_BITS'(($urandom_range(3) == 0) ? thr : $urandom_range(thr, 0));
        return int'(s);
    endfunction

    // Mostly bounce bursts that settle to a random target level, with some stray polls between
    task automatic queue_random_polls(input int count);
        int   n;
        int   iv;
        int   bounces;
        logic target;
        n  = 0;
        iv = int'(sw_cfg.interval_ms);
        while (n < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1) == 0)
                    offer_poll($urandom, $urandom_range(SAMPLE_MAX));
                else
                    offer_poll(t_ms + $urandom_range(2 * iv + 2), $urandom_range(SAMPLE_MAX));
                n++;
            end
            else
            begin
                target  = $urandom_range(1);
                bounces = $urandom_range(4);
                for (int k = 0; k < bounces; k++)
                begin
                    offer_poll(t_ms + $urandom_range(iv / 4 + 1), pick_sample(k[0] ^ target));
                    n++;
                end
                repeat ($urandom_range(5, 1))
                begin
                    offer_poll(t_ms + $urandom_range(iv + 3, iv / 2), pick_sample(target));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        poll_bus.valid        = 1'b0;
        poll_bus.now_ms       = '0;
        poll_bus.sample_value = '0;
        result_bus.ready      = 1'b0;
        sw_cfg.debounce_mode   = MODE_RESET;
        sw_cfg.interval_ms     = INTERVAL_RESET;
        sw_cfg.analog_input    = 1'b0;
        sw_cfg.noise_threshold = THRESHOLD_RESET;
        sw_level       = 1'b0;
        sw_raw_level   = 1'b0;
        sw_change_time = '0;
        sw_held        = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Stable interval at reset settings: settle, bounce, then a change across the wrap
        offer_poll(32'd0, 0);
        offer_poll(32'd4, 10'h3FE);
        offer_poll(32'd6, 1);
        offer_poll(32'd16, 1);
        offer_poll(32'd18, 0);
        offer_poll(32'd20, 10'h3FF);
        offer_poll(32'd22, 0);
        offer_poll(32'd32, 0);
        offer_poll(32'hFFFF_FFFA, 1);
        offer_poll(32'h0000_0004, 1);
        wait_idle();

        // Lock-out: polls inside the window keep the held sample
        write_reg(REG_MODE, DATA_BITS'(MODE_LOCKOUT));
        offer_poll(32'd8, 0);
        offer_poll(32'd14, 0);
        offer_poll(32'd15, 1);
        offer_poll(32'd23, 1);
        offer_poll(32'd24, 1);
        wait_idle();

        // Prompt: immediate change after a quiet raw line, otherwise wait to settle
        write_reg(REG_MODE, DATA_BITS'(MODE_PROMPT));
        offer_poll(32'd30, 0);
        offer_poll(32'd35, 0);
        offer_poll(32'd40, 0);
        offer_poll(32'd41, 1);
        offer_poll(32'd43, 0);
        offer_poll(32'd53, 0);
        wait_idle();

        // Unused mode code with analog samples around the threshold
        set_mode(MODE_SPARE, 0, 1'b1, 512);
        offer_poll(32'd60, 512);
        offer_poll(32'd61, 513);
        offer_poll(32'd62, SAMPLE_MAX);
        offer_poll(32'd63, 0);
        wait_idle();

        set_mode(MODE_STABLE, 10, 1'b0, 512);
        queue_random_polls(100);
        wait_idle();

        send_steady = 1'b1;
        recv_steady = 1'b1;
        set_mode(MODE_LOCKOUT, 5, 1'b0, 512);
        queue_random_polls(100);
        wait_idle();
        send_steady = 1'b0;
        recv_steady = 1'b0;

        set_mode(MODE_PROMPT, 3, 1'b1, 512);
        queue_random_polls(100);
        wait_idle();

        set_mode(MODE_SPARE, 0, 1'b1, 0);
        queue_random_polls(100);
        wait_idle();

        set_mode(MODE_LOCKOUT, 65535, 1'b1, SAMPLE_MAX);
        queue_random_polls(100);
        wait_idle();

        set_mode(MODE_PROMPT, 0, 1'b0, 0);
        queue_random_polls(100);
        wait_idle();

        set_mode(MODE_STABLE, 65535, 1'b0, 100);
        queue_random_polls(100);
        wait_idle();

        repeat (2)
        begin
            set_mode(2'($urandom_range(3)), $urandom_range(40), 1'($urandom_range(1)),
                     $urandom_range(SAMPLE_MAX));
            queue_random_polls(100);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("switch_debouncer_three_mode test passed");
        else
            $display("switch_debouncer_three_mode test failed");
        $finish;
    end

endmodule
